>>> rtl/core/msr_pkg.sv
// ---------------------------------------------------------------------------
// msr_pkg
// shared constants and types for the maximum-sum rectangle unit
// ---------------------------------------------------------------------------
package msr_pkg;

    // default geometry and element width
    localparam int MAX_ROWS  = 32;
    localparam int MAX_COLS  = 32;
    localparam int ELEM_BITS = 16;

    // port widths fixed by the interface
    localparam int VALUE_W    = 16;
    localparam int OUT_SUM_W  = 26;
    localparam int BOUND_W    = 5;
    localparam int CFG_W      = 6;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // reset value of both dimension registers
    localparam int CFG_RESET = 32;

    // register map, one word per register
    typedef enum logic {
        REG_ROWS_IN_USE = 1'b0,
        REG_COLS_IN_USE = 1'b1
    } reg_idx_t;

endpackage

>>> rtl/core/max_sum_rectangle_unit.sv
// ---------------------------------------------------------------------------
// max_sum_rectangle_unit
// loads a signed matrix row-major and reports the rectangle of greatest sum
// (two-dimensional kadane over every left/right column pair)
// ---------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------
//  input     | in_valid / in_stall    | value, last
//  output    | out_valid / out_stall  | best_sum, top_row, bottom_row,
//            |                        | left_col, right_col
//  config    | apb psel/penable/...   | rows_in_use @ 0x0, cols_in_use @ 0x4
//
//  load: one element request per cycle, written straight into the matrix ram
//  search: steps through every row of each column band in turn, then drains
//    the pipeline and hands the result off; paced by the single read port
//    of the matrix ram and the band-sum ram
//  in_stall is high from the last request until the result is in the
//    output register; a waiting result does not block the next load
//  reset: async active low, no memory clearing pass
//
module max_sum_rectangle_unit #(
    parameter int MAX_ROWS  = msr_pkg::MAX_ROWS,
    parameter int MAX_COLS  = msr_pkg::MAX_COLS,
    parameter int ELEM_BITS = msr_pkg::ELEM_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input requests
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [msr_pkg::VALUE_W-1:0]   value,
    input  logic                                 last,
    // result requests
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [msr_pkg::OUT_SUM_W-1:0] best_sum,
    output logic [msr_pkg::BOUND_W-1:0]          top_row,
    output logic [msr_pkg::BOUND_W-1:0]          bottom_row,
    output logic [msr_pkg::BOUND_W-1:0]          left_col,
    output logic [msr_pkg::BOUND_W-1:0]          right_col,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [msr_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [msr_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [msr_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int RDIM_W = $clog2(MAX_ROWS + 1);
    localparam int CDIM_W = $clog2(MAX_COLS + 1);
    // exact sum of up to DEPTH elements
    localparam int SUM_W  = ELEM_BITS + $clog2(DEPTH);
    localparam int EXT_W  = (SUM_W > msr_pkg::OUT_SUM_W) ? SUM_W : msr_pkg::OUT_SUM_W;

    localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(2**(msr_pkg::OUT_SUM_W-1) - 1);
    localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(-(2**(msr_pkg::OUT_SUM_W-1)));

    typedef enum logic [1:0] {
        S_LOAD,
        S_SEARCH,
        S_DRAIN,
        S_EMIT
    } state_t;

    // configuration registers
    logic [msr_pkg::CFG_W-1:0] rows_cfg_reg;
    logic [msr_pkg::CFG_W-1:0] cols_cfg_reg;
    logic                      cfg_we;
    msr_pkg::reg_idx_t         cfg_idx;

    // effective geometry
    logic [RDIM_W-1:0] rows_eff;
    logic [CDIM_W-1:0] cols_eff;
    logic [ROW_W-1:0]  rows_last;
    logic [COL_W-1:0]  cols_last;
    logic [CNT_W-1:0]  cap;

    // control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  load_count_reg, load_count_next;
    logic [COL_W-1:0]  l_reg, l_next;
    logic [COL_W-1:0]  r_reg, r_next;
    logic [ROW_W-1:0]  i_reg, i_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              in_accept;
    logic              start_search;
    logic              issue;
    logic              out_free;

    // output registers
    logic                                 out_valid_reg, out_valid_next;
    logic signed [msr_pkg::OUT_SUM_W-1:0] best_sum_reg;
    logic [msr_pkg::BOUND_W-1:0]          top_row_reg;
    logic [msr_pkg::BOUND_W-1:0]          bottom_row_reg;
    logic [msr_pkg::BOUND_W-1:0]          left_col_reg;
    logic [msr_pkg::BOUND_W-1:0]          right_col_reg;

    // memory ports
    logic                  mat_we;
    logic [ADDR_W-1:0]     mat_raddr;
    logic [ELEM_BITS-1:0]  mat_wdata;
    logic [ELEM_BITS-1:0]  mat_rdata;
    logic [SUM_W-1:0]      band_rdata;

    // stage 1: band update and row scan
    logic              s1_valid_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic              s1_first_reg;
    logic              s1_lastrow_reg;
    logic [COL_W-1:0]  s1_l_reg;
    logic [COL_W-1:0]  s1_r_reg;
    logic              fwd_valid_reg;
    logic signed [SUM_W-1:0] fwd_data_reg;

    logic signed [ELEM_BITS-1:0] elem;
    logic signed [SUM_W-1:0]     band_old;
    logic signed [SUM_W-1:0]     band_new;
    logic                        scan_start;
    logic signed [SUM_W-1:0]     run_in;
    logic signed [SUM_W-1:0]     run_sum;
    logic                        found_in;
    logic [ROW_W-1:0]            from_in;

    logic signed [SUM_W-1:0] run_reg, run_next;
    logic [ROW_W-1:0]        from_reg, from_next;
    logic                    found_reg, found_next;
    logic signed [SUM_W-1:0] kbest_reg, kbest_next;
    logic [ROW_W-1:0]        ktop_reg, ktop_next;
    logic [ROW_W-1:0]        kbot_reg, kbot_next;
    logic signed [SUM_W-1:0] fmax_reg, fmax_next;
    logic [ROW_W-1:0]        fidx_reg, fidx_next;

    // stage 2: band result against running best
    logic                    s2_valid_reg;
    logic [COL_W-1:0]        s2_l_reg;
    logic [COL_W-1:0]        s2_r_reg;
    logic signed [SUM_W-1:0] cand_sum;
    logic [ROW_W-1:0]        cand_top;
    logic [ROW_W-1:0]        cand_bot;
    logic                    have_reg;
    logic signed [SUM_W-1:0] best_reg;
    logic [ROW_W-1:0]        best_top_reg;
    logic [ROW_W-1:0]        best_bot_reg;
    logic [COL_W-1:0]        best_l_reg;
    logic [COL_W-1:0]        best_r_reg;

    logic signed [EXT_W-1:0] best_ext;
    logic signed [EXT_W-1:0] best_sat;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = msr_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= msr_pkg::CFG_W'(msr_pkg::CFG_RESET);
            cols_cfg_reg <= msr_pkg::CFG_W'(msr_pkg::CFG_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                msr_pkg::REG_ROWS_IN_USE: rows_cfg_reg <= pwdata[msr_pkg::CFG_W-1:0];
                msr_pkg::REG_COLS_IN_USE: cols_cfg_reg <= pwdata[msr_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            msr_pkg::REG_ROWS_IN_USE: prdata = msr_pkg::APB_DATA_W'(rows_cfg_reg);
            msr_pkg::REG_COLS_IN_USE: prdata = msr_pkg::APB_DATA_W'(cols_cfg_reg);
            default:                  prdata = '0;
        endcase
    end

    // zero acts as one, oversize clamps to the maximum
    always_comb
    begin
        if (rows_cfg_reg == '0)
            rows_eff = RDIM_W'(1);
        else if (rows_cfg_reg > MAX_ROWS)
            rows_eff = RDIM_W'(MAX_ROWS);
        else
            rows_eff = RDIM_W'(rows_cfg_reg);

        if (cols_cfg_reg == '0)
            cols_eff = CDIM_W'(1);
        else if (cols_cfg_reg > MAX_COLS)
            cols_eff = CDIM_W'(MAX_COLS);
        else
            cols_eff = CDIM_W'(cols_cfg_reg);
    end

    assign rows_last = ROW_W'(rows_eff - RDIM_W'(1));
    assign cols_last = COL_W'(cols_eff - CDIM_W'(1));
    assign cap       = CNT_W'(rows_eff) * CNT_W'(cols_eff);

    // ------------------------------------------------------------------
    // sequencer: load, walk column bands and rows, drain, emit
    // ------------------------------------------------------------------
    assign in_stall     = (state_reg != S_LOAD);
    assign in_accept    = in_valid && !in_stall;
    assign start_search = in_accept && last;
    assign issue        = (state_reg == S_SEARCH);
    assign out_free     = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        l_next          = l_reg;
        r_next          = r_reg;
        i_next          = i_reg;
        addr_next       = addr_reg;
        out_valid_next  = out_valid_reg && out_stall;

        case (state_reg)
            S_LOAD:
            begin
                if (in_accept)
                begin
                    if (load_count_reg < cap)
                        load_count_next = load_count_reg + CNT_W'(1);
                    if (last)
                    begin
                        load_count_next = '0;
                        l_next          = '0;
                        r_next          = '0;
                        i_next          = '0;
                        addr_next       = '0;
                        state_next      = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (i_reg == rows_last)
                begin
                    i_next = '0;
                    if (r_reg == cols_last)
                    begin
                        if (l_reg == cols_last)
                        begin
                            state_next = S_DRAIN;
                        end
                        else
                        begin
                            // next left column, band restarts one column wide at that column
                            l_next    = l_reg + COL_W'(1);
                            r_next    = l_reg + COL_W'(1);
                            addr_next = ADDR_W'(l_reg) + ADDR_W'(1);
                        end
                    end
                    else
                    begin
                        r_next    = r_reg + COL_W'(1);
                        addr_next = ADDR_W'(r_reg) + ADDR_W'(1);
                    end
                end
                else
                begin
                    i_next    = i_reg + ROW_W'(1);
                    addr_next = addr_reg + ADDR_W'(cols_eff);
                end
            end
            S_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // saturate the exact sum into the result field
    assign best_ext = EXT_W'(best_reg);
    assign best_sat = (best_ext > SAT_HI) ? SAT_HI :
                      (best_ext < SAT_LO) ? SAT_LO : best_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            load_count_reg <= '0;
            l_reg          <= '0;
            r_reg          <= '0;
            i_reg          <= '0;
            addr_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            l_reg          <= l_next;
            r_reg          <= r_next;
            i_reg          <= i_next;
            addr_reg       <= addr_next;
            out_valid_reg  <= out_valid_next;
            if (state_reg == S_EMIT && out_free)
            begin
                best_sum_reg   <= msr_pkg::OUT_SUM_W'(best_sat);
                top_row_reg    <= msr_pkg::BOUND_W'(best_top_reg);
                bottom_row_reg <= msr_pkg::BOUND_W'(best_bot_reg);
                left_col_reg   <= msr_pkg::BOUND_W'(best_l_reg);
                right_col_reg  <= msr_pkg::BOUND_W'(best_r_reg);
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign best_sum   = best_sum_reg;
    assign top_row    = top_row_reg;
    assign bottom_row = bottom_row_reg;
    assign left_col   = left_col_reg;
    assign right_col  = right_col_reg;

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    // element masked to ELEM_BITS, read back as signed
    assign mat_we    = in_accept && (load_count_reg < cap);
    assign mat_wdata = ELEM_BITS'($unsigned(value));
    assign mat_raddr = addr_reg;

    msr_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (DEPTH)
    ) u_matrix_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr (load_count_reg[ADDR_W-1:0]),
        .wdata (mat_wdata),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    msr_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_ROWS)
    ) u_band_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_row_reg),
        .wdata (band_new),
        .raddr (i_reg),
        .rdata (band_rdata)
    );

    // ------------------------------------------------------------------
    // stage 1: band row sum update plus kadane and single-row max
    // ------------------------------------------------------------------
    assign elem = signed'(mat_rdata);

    // first band of a left column starts from zero; a one-row matrix reads
    // the row it is writing in the same cycle, so take the forwarded sum
    always_comb
    begin
        if (s1_first_reg)
            band_old = '0;
        else if (fwd_valid_reg)
            band_old = fwd_data_reg;
        else
            band_old = signed'(band_rdata);
    end

    assign band_new   = band_old + SUM_W'(elem);
    assign scan_start = (s1_row_reg == '0);
    assign run_in     = scan_start ? '0 : run_reg;
    assign found_in   = scan_start ? 1'b0 : found_reg;
    assign from_in    = scan_start ? '0 : from_reg;
    assign run_sum    = run_in + band_new;

    always_comb
    begin
        run_next   = run_sum;
        from_next  = from_in;
        found_next = found_in;
        kbest_next = kbest_reg;
        ktop_next  = ktop_reg;
        kbot_next  = kbot_reg;
        fmax_next  = fmax_reg;
        fidx_next  = fidx_reg;

        if (run_sum < 0)
        begin
            run_next  = '0;
            from_next = s1_row_reg + ROW_W'(1);
        end
        else if (!found_in || run_sum > kbest_reg)
        begin
            kbest_next = run_sum;
            ktop_next  = from_in;
            kbot_next  = s1_row_reg;
            found_next = 1'b1;
        end

        // fallback when every running sum goes negative: first largest row
        if (scan_start || band_new > fmax_reg)
        begin
            fmax_next = band_new;
            fidx_next = s1_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= issue;
            fwd_valid_reg <= issue && s1_valid_reg && (s1_row_reg == i_reg);
            s2_valid_reg  <= s1_valid_reg && s1_lastrow_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_row_reg     <= i_reg;
        s1_first_reg   <= (r_reg == l_reg);
        s1_lastrow_reg <= (i_reg == rows_last);
        s1_l_reg       <= l_reg;
        s1_r_reg       <= r_reg;
        fwd_data_reg   <= band_new;
        if (s1_valid_reg)
        begin
            run_reg   <= run_next;
            from_reg  <= from_next;
            found_reg <= found_next;
            kbest_reg <= kbest_next;
            ktop_reg  <= ktop_next;
            kbot_reg  <= kbot_next;
            fmax_reg  <= fmax_next;
            fidx_reg  <= fidx_next;
            s2_l_reg  <= s1_l_reg;
            s2_r_reg  <= s1_r_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: compare the finished band with the best so far
    // ------------------------------------------------------------------
    assign cand_sum = found_reg ? kbest_reg : fmax_reg;
    assign cand_top = found_reg ? ktop_reg : fidx_reg;
    assign cand_bot = found_reg ? kbot_reg : fidx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (start_search)
        begin
            have_reg <= 1'b0;
        end
        else if (s2_valid_reg)
        begin
            have_reg <= 1'b1;
        end
    end

    // ties keep the earlier band
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && (!have_reg || cand_sum > best_reg))
        begin
            best_reg     <= cand_sum;
            best_top_reg <= cand_top;
            best_bot_reg <= cand_bot;
            best_l_reg   <= s2_l_reg;
            best_r_reg   <= s2_r_reg;
        end
    end

endmodule

>>> rtl/core/msr_ram.sv
// ---------------------------------------------------------------------------
// msr_ram
// generic simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module msr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/msr_checker.sv
// ---------------------------------------------------------------------------
// msr_checker
// port-level checks for the maximum-sum rectangle unit
// ---------------------------------------------------------------------------
module msr_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 last,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [msr_pkg::OUT_SUM_W-1:0] best_sum,
    input logic [msr_pkg::BOUND_W-1:0]          top_row,
    input logic [msr_pkg::BOUND_W-1:0]          bottom_row,
    input logic [msr_pkg::BOUND_W-1:0]          left_col,
    input logic [msr_pkg::BOUND_W-1:0]          right_col
);

    // a last request starts the search, so no further request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last |=> in_stall)
        else $error("request accepted right after a last request");

    // a result only appears after a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a search");

    // rectangle bounds are ordered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (top_row <= bottom_row) && (left_col <= right_col))
        else $error("result rectangle bounds out of order");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(best_sum)
            && $stable(top_row) && $stable(bottom_row)
            && $stable(left_col) && $stable(right_col))
        else $error("stalled result changed");

endmodule

bind max_sum_rectangle_unit msr_checker u_msr_checker (.*);

>>> dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the maximum-sum rectangle unit: loads matrices of
// many shapes over the valid/stall channel, predicts the best rectangle with
// a 2-d kadane search of its own and checks every result field by field
// ---------------------------------------------------------------------------
module tb;

    // run limits and pacing
    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES  = 2000;    // long output hold-off
    localparam int SETTLE_GAP   = 8;       // idle cycles before a register write
    localparam int TAIL_CYCLES  = 40;      // quiet window after the last result
    localparam int CYCLE_LIMIT  = 2000000;

    localparam longint SUM_HI = (longint'(1) <<< (msr_pkg::OUT_SUM_W - 1)) - 1;
    localparam longint SUM_LO = -(longint'(1) <<< (msr_pkg::OUT_SUM_W - 1));

    // how element values are drawn
    typedef enum int {
        STYLE_SMALL,
        STYLE_WIDE,
        STYLE_NEGATIVE,
        STYLE_EXTREME,
        STYLE_TOP
    } value_style_t;

    // how many elements a matrix request stream carries
    typedef enum int {
        SHAPE_EXACT,
        SHAPE_SHORT,
        SHAPE_LONG
    } matrix_shape_t;

    // one search result
    typedef struct {
        logic signed [msr_pkg::OUT_SUM_W-1:0] best_sum;
        logic [msr_pkg::BOUND_W-1:0]          top_row;
        logic [msr_pkg::BOUND_W-1:0]          bottom_row;
        logic [msr_pkg::BOUND_W-1:0]          left_col;
        logic [msr_pkg::BOUND_W-1:0]          right_col;
    } rect_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_stall;
    logic signed [msr_pkg::VALUE_W-1:0]   value;
    logic                                 last;
    logic                                 out_valid;
    logic                                 out_stall;
    logic signed [msr_pkg::OUT_SUM_W-1:0] best_sum;
    logic [msr_pkg::BOUND_W-1:0]          top_row;
    logic [msr_pkg::BOUND_W-1:0]          bottom_row;
    logic [msr_pkg::BOUND_W-1:0]          left_col;
    logic [msr_pkg::BOUND_W-1:0]          right_col;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [msr_pkg::APB_ADDR_W-1:0]       paddr;
    logic [msr_pkg::APB_DATA_W-1:0]       pwdata;
    logic [msr_pkg::APB_DATA_W-1:0]       prdata;
    logic                                 pready;

    // predictor state: matrix copy, load position, written prefix, registers
    longint                    matrix_copy [msr_pkg::MAX_ROWS*msr_pkg::MAX_COLS];
    int                        fill_count    = 0;
    int                        written_upto  = 0;
    logic [msr_pkg::CFG_W-1:0] geometry_regs [2] = '{msr_pkg::CFG_RESET, msr_pkg::CFG_RESET};

    // results still owed by the block, oldest first
    rect_t              pending_rects [$];

    int                 mismatches    = 0;
    int                 cycle_count   = 0;
    int                 burst_left    = 1;
    bit                 offering      = 0;
    bit                 hold_req      = 0;

    max_sum_rectangle_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .best_sum   (best_sum),
        .top_row    (top_row),
        .bottom_row (bottom_row),
        .left_col   (left_col),
        .right_col  (right_col),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog, counts every cycle of the run
    initial
    begin : watchdog
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // register value as the search uses it: 0 means 1, too large means max
    function automatic int eff_dim(logic [msr_pkg::CFG_W-1:0] raw, int limit);
        if (raw == '0)
            return 1;
        if (int'(raw) > limit)
            return limit;
        return int'(raw);
    endfunction

    function automatic int current_capacity();
        return eff_dim(geometry_regs[msr_pkg::REG_ROWS_IN_USE], msr_pkg::MAX_ROWS)
             * eff_dim(geometry_regs[msr_pkg::REG_COLS_IN_USE], msr_pkg::MAX_COLS);
    endfunction

    // every left/right column pair, kadane down the band row sums
    function automatic rect_t find_best_rectangle(int nrows, int ncols);
        rect_t  res;
        longint band [msr_pkg::MAX_ROWS];
        longint run;
        longint kbest;
        longint best;
        int     from;
        int     t;
        int     b;
        bit     found;
        bit     have;
        have = 0;
        best = SUM_LO;
        t    = 0;
        b    = 0;
        res.top_row    = '0;
        res.bottom_row = '0;
        res.left_col   = '0;
        res.right_col  = '0;
        for (int l = 0; l < ncols; l++)
        begin
            for (int i = 0; i < msr_pkg::MAX_ROWS; i++)
                band[i] = 0;
            for (int rc = l; rc < ncols; rc++)
            begin
                for (int i = 0; i < nrows; i++)
                    band[i] += matrix_copy[i * ncols + rc];
                run   = 0;
                kbest = 0;
                from  = 0;
                found = 0;
                for (int i = 0; i < nrows; i++)
                begin
                    run += band[i];
                    if (run < 0)
                    begin
                        run  = 0;
                        from = i + 1;
                    end
                    else if (!found || run > kbest)
                    begin
                        kbest = run;
                        t     = from;
                        b     = i;
                        found = 1;
                    end
                end
                // all row sums negative: best single row, first one wins ties
                if (!found)
                begin
                    kbest = band[0];
                    t     = 0;
                    b     = 0;
                    for (int i = 1; i < nrows; i++)
                    begin
                        if (band[i] > kbest)
                        begin
                            kbest = band[i];
                            t     = i;
                            b     = i;
                        end
                    end
                end
                if (!have || kbest > best)
                begin
                    have           = 1;
                    best           = kbest;
                    res.top_row    = msr_pkg::BOUND_W'(t);
                    res.bottom_row = msr_pkg::BOUND_W'(b);
                    res.left_col   = msr_pkg::BOUND_W'(l);
                    res.right_col  = msr_pkg::BOUND_W'(rc);
                end
            end
        end
        if (best > SUM_HI)
            best = SUM_HI;
        if (best < SUM_LO)
            best = SUM_LO;
        res.best_sum = msr_pkg::OUT_SUM_W'(best);
        return res;
    endfunction

    // one accepted element: store it while there is room, search on the mark
    task automatic absorb_element(logic signed [msr_pkg::VALUE_W-1:0] v, bit is_last);
        if (fill_count < current_capacity())
        begin
            matrix_copy[fill_count] = longint'(v);
            fill_count++;
            if (fill_count > written_upto)
                written_upto = fill_count;
        end
        if (is_last)
        begin
            pending_rects.push_back(find_best_rectangle(
                eff_dim(geometry_regs[msr_pkg::REG_ROWS_IN_USE], msr_pkg::MAX_ROWS),
                eff_dim(geometry_regs[msr_pkg::REG_COLS_IN_USE], msr_pkg::MAX_COLS)));
            fill_count = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // output stall pattern; a pending hold request takes priority
    initial
    begin : result_stall
        int hold_left;
        int mode_left;
        int stall_pct;
        hold_left = 0;
        mode_left = 0;
        stall_pct = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(20, 200);
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 30;
                        3:       stall_pct = 70;
                        default: stall_pct = 95;
                    endcase
                end
                mode_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    task automatic compare_field(string what, longint want, longint got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t mismatch %s: expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    // compare each accepted result with the oldest expectation
    initial
    begin : result_check
        rect_t want;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_rects.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected result: sum %0d rows %0d..%0d cols %0d..%0d",
                             $time, best_sum, top_row, bottom_row, left_col, right_col);
                end
                else
                begin
                    want = pending_rects.pop_front();
                    compare_field("best_sum", want.best_sum, best_sum);
                    compare_field("top_row", want.top_row, top_row);
                    compare_field("bottom_row", want.bottom_row, bottom_row);
                    compare_field("left_col", want.left_col, left_col);
                    compare_field("right_col", want.right_col, right_col);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // offer one element until accepted, then maybe close the burst
    task automatic send_element(logic signed [msr_pkg::VALUE_W-1:0] v, bit is_last);
        in_valid <= 1'b1;
        value    <= v;
        last     <= is_last;
        offering = 1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        absorb_element(v, is_last);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            // some bursts run straight into the next one
            if ($urandom_range(0, 9) >= 3)
            begin
                in_valid <= 1'b0;
                offering = 0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    task automatic sender_idle();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 0;
        end
    endtask

    // pause the sender until every owed result has come back
    task automatic wait_drain();
        sender_idle();
        while (pending_rects.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [msr_pkg::VALUE_W-1:0] pick_value(value_style_t style);
        logic signed [msr_pkg::VALUE_W-1:0] v;
        int                                 pick;
        pick = $urandom_range(0, 99);
        v    = msr_pkg::VALUE_W'($urandom);
        case (style)
            STYLE_SMALL:
                if (pick >= 10)
                    v = msr_pkg::VALUE_W'(int'($urandom_range(0, 40)) - 20);
            STYLE_NEGATIVE:
                if (pick >= 5)
                    v = msr_pkg::VALUE_W'(-int'($urandom_range(1, 3000)));
                else
                    v = 16'sh8000;
            STYLE_EXTREME:
                case ($urandom_range(0, 4))
                    0:       v = 16'sh7fff;
                    1:       v = 16'sh8000;
                    2:       v = 16'sh0000;
                    3:       v = 16'sh0001;
                    default: v = 16'shffff;
                endcase
            STYLE_TOP:
                if (pick < 95)
                    v = 16'sh7fff;
            default: ;
        endcase
        return v;
    endfunction

    // n elements, mark on the final one
    task automatic send_matrix(int n, value_style_t style);
        for (int k = 0; k < n; k++)
            send_element(pick_value(style), k == n - 1);
    endtask

    task automatic send_values(int vals[$]);
        for (int k = 0; k < vals.size(); k++)
            send_element(msr_pkg::VALUE_W'(vals[k]), k == vals.size() - 1);
    endtask

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------

    task automatic check_register(msr_pkg::reg_idx_t idx);
        logic [msr_pkg::APB_DATA_W-1:0] data;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        compare_field(idx.name(), msr_pkg::APB_DATA_W'(geometry_regs[idx]), data);
    endtask

    // write with junk in the upper bits, then read it back
    task automatic write_register(msr_pkg::reg_idx_t idx, logic [msr_pkg::CFG_W-1:0] raw);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {(msr_pkg::APB_DATA_W - msr_pkg::CFG_W)'($urandom), raw};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        geometry_regs[idx] = raw;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        check_register(idx);
    endtask

    // new geometry, only once the block has gone quiet
    task automatic set_geometry(int rows_raw, int cols_raw);
        wait_drain();
        repeat (SETTLE_GAP) @(posedge clk);
        write_register(msr_pkg::REG_ROWS_IN_USE, msr_pkg::CFG_W'(rows_raw));
        write_register(msr_pkg::REG_COLS_IN_USE, msr_pkg::CFG_W'(cols_raw));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // both dimension registers come out of reset at full size
    task automatic test_register_reset();
        check_register(msr_pkg::REG_ROWS_IN_USE);
        check_register(msr_pkg::REG_COLS_IN_USE);
    endtask

    // zero in both registers acts as a 1x1 matrix; largest and smallest value
    task automatic test_single_element();
        set_geometry(0, 0);
        send_values('{32767});
        send_values('{-32768});
    endtask

    // 2x2 with mixed signs
    task automatic test_mixed_band();
        set_geometry(2, 2);
        send_values('{3, -8, -2, 9});
    endtask

    // every row sum negative: largest single row, first of equal ones kept
    task automatic test_all_negative();
        set_geometry(3, 2);
        send_values('{-7, -3, -9, -1, -4, -1});
    endtask

    // equal sums: the first rectangle found stays
    task automatic test_ties();
        set_geometry(1, 3);
        send_values('{5, -5, 5});
    endtask

    // mark on the first element: rest of the store keeps older values
    task automatic test_early_last();
        set_geometry(2, 2);
        send_values('{100});
    endtask

    // elements past rows*cols are dropped, mark still ends the matrix
    task automatic test_overlong();
        set_geometry(1, 2);
        send_values('{7, 8, -1000, 12});
    endtask

    // random geometries and matrix shapes, mostly well-formed and small
    task automatic test_random_matrices();
        int            sent;
        int            rows_raw;
        int            cols_raw;
        int            cap;
        int            n;
        matrix_shape_t shape;
        value_style_t  style;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            rows_raw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            cols_raw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            // now and then one dimension goes large, possibly out of range
            case ($urandom_range(0, 9))
                8:       rows_raw = ($urandom_range(0, 1) == 0) ? 32 : $urandom_range(9, 63);
                9:       cols_raw = ($urandom_range(0, 1) == 0) ? 32 : $urandom_range(9, 63);
                default: ;
            endcase
            set_geometry(rows_raw, cols_raw);
            cap = current_capacity();
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 9))
                    0:       shape = SHAPE_SHORT;
                    1:       shape = SHAPE_LONG;
                    default: shape = SHAPE_EXACT;
                endcase
                // a short matrix may only lean on entries written before
                if (shape == SHAPE_SHORT && (cap < 2 || cap > written_upto))
                    shape = SHAPE_EXACT;
                case (shape)
                    SHAPE_SHORT: n = $urandom_range(1, cap - 1);
                    SHAPE_LONG:  n = cap + $urandom_range(1, 4);
                    default:     n = cap;
                endcase
                case ($urandom_range(0, 4))
                    0, 1:    style = STYLE_SMALL;
                    2:       style = STYLE_WIDE;
                    3:       style = STYLE_NEGATIVE;
                    default: style = STYLE_EXTREME;
                endcase
                send_matrix(n, style);
                sent += n;
                if ($urandom_range(0, 9) == 0)
                    wait_drain();
            end
        end
    endtask

    // all rows in use (rows register out of range), mostly top values,
    // then a short negative load searched over the same geometry
    task automatic test_full_size();
        set_geometry(45, 6);
        send_matrix(current_capacity(), STYLE_TOP);
        send_matrix(40, STYLE_NEGATIVE);
    endtask

    // receiver holds off while the sender keeps going until the input stalls
    task automatic test_backpressure();
        set_geometry(2, 3);
        hold_req = 1;
        repeat (3) send_matrix(current_capacity(), STYLE_SMALL);
        wait_drain();
        send_matrix(current_capacity(), STYLE_WIDE);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        value    <= '0;
        last     <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_single_element();
        test_mixed_band();
        test_all_negative();
        test_ties();
        test_early_last();
        test_overlong();
        test_random_matrices();
        test_full_size();
        test_backpressure();

        // everything owed, then a quiet window for stray results
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
